// ----- src/ssmg_pkg.sv -----
// Shared constants, types and helpers for the sorted set gap tracker.
// No dependencies; used by the cell, the top level and the checker.
package ssmg_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Per-cell flags seen by the top level
  typedef struct packed {
    logic le;        // occupied and not above the incoming word
    logic ins_here;  // incoming word lands in this cell
  } cell_flags_t;

  typedef enum logic {
    ST_IDLE,
    ST_FIN
  } ctrl_state_t;

  // Flip the sign bit so unsigned compare gives signed order
  function automatic data_t order_key(input data_t v);
    return v ^ {1'b1, {(DATA_W-1){1'b0}}};
  endfunction

endpackage

// ----- src/ssmg_cell.sv -----
// One slot of the sorted chain: holds a word and shifts or inserts on command.
// Depends on ssmg_pkg.
module ssmg_cell
  import ssmg_pkg::*;
(
  input  logic        clk,
  input  logic        ins_en,
  input  data_t       new_value,
  input  data_t       left_value,
  input  logic        left_le,
  input  logic        occ,
  output data_t       value,
  output cell_flags_t flags
);

  // Position flags: cells below the insert point keep, the insert point takes
  // the new word, everything above takes its left neighbor.
  always_comb begin
    flags.le       = occ && (order_key(value) <= order_key(new_value));
    flags.ins_here = !flags.le && left_le;
  end

  always_ff @(posedge clk) begin
    if (ins_en && !flags.le) begin
      value <= left_le ? new_value : left_value;
    end
  end

endmodule

// ----- src/sorted_set_min_max_gap.sv -----
// Sorted bounded set with shortest neighbor gap and full span.
// Top level; depends on ssmg_pkg and ssmg_cell.
//
// Input channel (in_valid/in_ready, value): one signed 32-bit word per item.
// Output channel (out_valid/out_ready): one result word per input word with
// status, count, spans_valid, shortest_gap and longest_gap.
// Config: cfg_wr_en/cfg_wr_data write the capacity register at once.
//
// An accepted word is compared against all 64 cells in parallel and the
// chain shifts right of the insert point at the accept edge. The next cycle
// computes the two new neighbor gaps and the span and loads the output
// register, which raises out_valid. The finish cycle that follows every
// accepted word holds off the next word, so words are taken one at a time.
// in_ready is low during the finish cycle and while an untaken result sits
// in the output register; a stalled receiver therefore stalls the input.
// Reset empties the set, restores capacity to 64 and the shortest gap to all
// ones; the cell contents are not cleared, only the count marks them live.
module sorted_set_min_max_gap
  import ssmg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             status,
  output logic [6:0]       count,
  output logic             spans_valid,
  output logic [31:0]      shortest_gap,
  output logic [31:0]      longest_gap
);

  ctrl_state_t      state, state_next;
  logic [CAP_W-1:0] capacity;
  cnt_t             held_count;
  data_t            min_gap;
  data_t            max_val;
  data_t            v_reg;
  data_t            left_val, right_val;
  logic             has_left, has_right;
  logic             inserted;

  data_t            cell_val   [MAX_ENTRIES];
  cell_flags_t      cell_flags [MAX_ENTRIES];
  logic             cell_occ   [MAX_ENTRIES];

  logic             accept, full, ins_en;
  cnt_t             limit;
  data_t            sel_left, sel_right;
  logic             sel_right_occ, sel_at_head;
  data_t            gap_l, gap_r, min_next;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Effective limit and full check
  always_comb begin
    limit  = (CNT_W'(capacity) < CNT_W'(MAX_ENTRIES)) ? CNT_W'(capacity)
                                                       : CNT_W'(MAX_ENTRIES);
    full   = held_count >= limit;
    accept = in_valid && in_ready;
    ins_en = accept && !full;
  end

  // Cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign cell_occ[i] = CNT_W'(i) < held_count;
    if (i == 0) begin : g_head
      ssmg_cell u_cell (
        .clk        (clk),
        .ins_en     (ins_en),
        .new_value  (value),
        .left_value ('0),
        .left_le    (1'b1),
        .occ        (cell_occ[i]),
        .value      (cell_val[i]),
        .flags      (cell_flags[i])
      );
    end else begin : g_body
      ssmg_cell u_cell (
        .clk        (clk),
        .ins_en     (ins_en),
        .new_value  (value),
        .left_value (cell_val[i-1]),
        .left_le    (cell_flags[i-1].le),
        .occ        (cell_occ[i]),
        .value      (cell_val[i]),
        .flags      (cell_flags[i])
      );
    end
  end

  // One-hot pick of the neighbors around the insert point
  always_comb begin
    sel_left      = '0;
    sel_right     = '0;
    sel_right_occ = 1'b0;
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      if (cell_flags[i].ins_here) begin
        sel_left = sel_left | cell_val[i-1];
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cell_flags[i].ins_here) begin
        sel_right     = sel_right | cell_val[i];
        sel_right_occ = sel_right_occ | cell_occ[i];
      end
    end
    sel_at_head = cell_flags[0].ins_here;
  end

  // Insert-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (ins_en) begin
      held_count <= held_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_reg     <= value;
      left_val  <= sel_left;
      right_val <= sel_right;
      has_left  <= !sel_at_head;
      has_right <= sel_right_occ;
      inserted  <= !full;
      if (!full && !sel_right_occ) begin
        max_val <= value;
      end
    end
  end

  // New neighbor gaps and running minimum
  always_comb begin
    gap_l    = v_reg - left_val;
    gap_r    = right_val - v_reg;
    min_next = min_gap;
    if (has_left && (gap_l < min_next)) begin
      min_next = gap_l;
    end
    if (has_right && (gap_r < min_next)) begin
      min_next = gap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= '1;
    end else if ((state == ST_FIN) && inserted) begin
      min_gap <= min_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      status      <= !inserted;
      count       <= 7'(held_count);
      spans_valid <= held_count >= CNT_W'(2);
      if (held_count >= CNT_W'(2)) begin
        shortest_gap <= inserted ? min_next : min_gap;
        longest_gap  <= max_val - cell_val[0];
      end else begin
        shortest_gap <= '0;
        longest_gap  <= '0;
      end
    end
  end

endmodule

// ----- src/ssmg_chk.sv -----
// Port-level checker for the sorted set gap tracker, bound to the top level.
// Depends on ssmg_pkg and sorted_set_min_max_gap.
module ssmg_chk
  import ssmg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic [6:0]  count,
  input logic        spans_valid,
  input logic [31:0] shortest_gap,
  input logic [31:0] longest_gap
);

  // A stalled result word holds its count
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count))
    else $error("result word changed while stalled");

  // One word at a time: no accept in the cycle after an accept
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during finish cycle");

  // Every accepted word raises out_valid once its finish cycle is over
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result word missing after accept");

  // Spans read zero with fewer than two words held
  a_spans: assert property (@(posedge clk) disable iff (rst)
    out_valid && !spans_valid |-> shortest_gap == 32'd0 && longest_gap == 32'd0
      && count < 7'd2)
    else $error("span fields set with fewer than two words");

  // An accepted word leaves at least one held
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> count != 7'd0)
    else $error("accepted word with empty set");

endmodule

bind sorted_set_min_max_gap ssmg_chk u_ssmg_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .count        (count),
  .spans_valid  (spans_valid),
  .shortest_gap (shortest_gap),
  .longest_gap  (longest_gap)
);

// ----- sim/ssmg_gap_checker.sv -----
`timescale 1ns / 100ps
// Checker for the sorted set gap tracker: watches the config, input and
// result channels, predicts each result word and compares it. Needs ssmg_pkg.
module ssmg_gap_checker
  import ssmg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [31:0]      value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             status,
  input  logic [6:0]       count,
  input  logic             spans_valid,
  input  logic [31:0]      shortest_gap,
  input  logic [31:0]      longest_gap,
  output int               pending,
  output int               failures
);

  typedef struct packed {
    logic        status;
    logic [6:0]  count;
    logic        spans_valid;
    logic [31:0] shortest_gap;
    logic [31:0] longest_gap;
  } gap_report_t;

  // Shadow of the set
  data_t            set_words [MAX_ENTRIES];
  int               set_size;
  data_t            tightest_gap;
  logic [CAP_W-1:0] capacity;

  gap_report_t gap_reports[$];

  initial begin
    pending  = 0;
    failures = 0;
  end

  // Insert one word into the shadow set and build the report it causes
  task automatic insert_and_report(input data_t word, output gap_report_t rep);
    int    limit;
    int    pos;
    int    i;
    data_t diff;
    limit = (int'(capacity) < MAX_ENTRIES) ? int'(capacity) : MAX_ENTRIES;
    rep = '0;
    if (set_size >= limit) begin
      rep.status = 1'b1;
    end else begin
      pos = 0;
      // duplicates go after their equals
      while (pos < set_size && $signed(set_words[pos]) <= $signed(word))
        pos++;
      for (i = set_size; i > pos; i--)
        set_words[i] = set_words[i-1];
      set_words[pos] = word;
      set_size++;
      if (pos > 0) begin
        diff = word - set_words[pos-1];
        if (diff < tightest_gap) tightest_gap = diff;
      end
      if (pos + 1 < set_size) begin
        diff = set_words[pos+1] - word;
        if (diff < tightest_gap) tightest_gap = diff;
      end
    end
    rep.count = 7'(set_size);
    if (set_size >= 2) begin
      rep.spans_valid  = 1'b1;
      rep.shortest_gap = tightest_gap;
      rep.longest_gap  = set_words[set_size-1] - set_words[0];
    end
  endtask

  // Track the channels and compare each result word
  always @(posedge clk) begin
    gap_report_t want;
    int          bad;
    bad = 0;
    if (rst) begin
      set_size     = 0;
      tightest_gap = '1;
      capacity     = CAP_RESET;
      gap_reports.delete();
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (in_valid && in_ready) begin
        insert_and_report(value, want);
        gap_reports = {gap_reports, want};
      end
      if (out_valid && out_ready) begin
        if (gap_reports.size() == 0) begin
          $error("result word with none expected");
          bad++;
        end else begin
          want = gap_reports.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            bad++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            bad++;
          end
          if (spans_valid !== want.spans_valid) begin
            $error("spans_valid: expected %0d, got %0d", want.spans_valid, spans_valid);
            bad++;
          end
          if (shortest_gap !== want.shortest_gap) begin
            $error("shortest_gap: expected %h, got %h", want.shortest_gap, shortest_gap);
            bad++;
          end
          if (longest_gap !== want.longest_gap) begin
            $error("longest_gap: expected %h, got %h", want.longest_gap, longest_gap);
            bad++;
          end
        end
      end
    end
    failures <= failures + bad;
    pending  <= gap_reports.size();
  end

endmodule

// ----- sim/sorted_set_min_max_gap_test.sv -----
`timescale 1ns / 100ps
// Top of the sorted set gap tracker testbench: clock, reset, stimulus and
// verdict. Needs ssmg_pkg, sorted_set_min_max_gap and ssmg_gap_checker.
module sorted_set_min_max_gap_test
  import ssmg_pkg::*;
();

  localparam int WORD_TARGET = 700;
  localparam int CYCLE_LIMIT = 300000;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [31:0]      value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             status;
  logic [6:0]       count;
  logic             spans_valid;
  logic [31:0]      shortest_gap;
  logic [31:0]      longest_gap;

  int pending;
  int failures;
  int idle_pct = 27;
  int words_sent = 0;
  int held = 0;        // values the set holds, tracked for stimulus shaping
  int cap_now = 64;
  int cycle_cnt = 0;

  sorted_set_min_max_gap dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .count(count), .spans_valid(spans_valid),
    .shortest_gap(shortest_gap), .longest_gap(longest_gap)
  );

  ssmg_gap_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .count(count), .spans_valid(spans_valid),
    .shortest_gap(shortest_gap), .longest_gap(longest_gap),
    .pending(pending), .failures(failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Present one word, with a random gap ahead of it; valid stays up on return
  task automatic send_word(input logic [31:0] word);
    int limit;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    value    <= word;
    do @(posedge clk); while (!in_ready);
    limit = (cap_now < MAX_ENTRIES) ? cap_now : MAX_ENTRIES;
    if (held < limit) held++;
    words_sent++;
    // a stretch with no idling on either side
    idle_pct = (words_sent >= 250 && words_sent < 400) ? 0 : 27;
  endtask

  // Drain the pipe, then write the capacity register
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_now = int'(cap);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = 32'(int'($urandom_range(0, 400)) - 200);
      2: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 50000)
                                  : 32'h7FFF_FFFF - $urandom_range(0, 50000);
      default: v = {$urandom_range(0, 1) ? 8'h00 : 8'hFF, 24'($urandom)};
    endcase
    // the last two free cells take the top value and a duplicate of the bottom
    if (held == MAX_ENTRIES - 2 && cap_now > held) v = 32'h7FFF_FFFF;
    if (held == MAX_ENTRIES - 1 && cap_now > held) v = 32'h8000_0000;
    return v;
  endfunction

  initial begin
    int          n;
    logic [31:0] cap_pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero capacity, single entry, extremes, capacity below count
    set_capacity(CAP_W'(0));
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'h0000_0000);
    set_capacity(CAP_W'(1));
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    set_capacity(CAP_W'(64));
    send_word(32'hFFFF_FFFF);
    set_capacity(CAP_W'(127));
    send_word(32'h0000_0001);
    set_capacity(CAP_W'(2));
    send_word(32'h0000_0005);
    set_capacity(CAP_W'(4));
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);

    // Random phases, each with its own capacity
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 7))
        0: cap_pick = 0;
        1: cap_pick = 64;
        2: cap_pick = 127;
        3: cap_pick = (held > 0) ? $urandom_range(0, held - 1) : 0;
        default: cap_pick = held + $urandom_range(1, 6);
      endcase
      if (cap_pick > 127) cap_pick = 127;
      set_capacity(CAP_W'(cap_pick));
      n = $urandom_range(5, 30);
      repeat (n) send_word(pick_value());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
